// ===== sv/okmu_pkg.sv =====
// Shared constants, codes and controller/datapath interface types for the k-means update block
`default_nettype none
package okmu_pkg;

	localparam int DEF_MAX_CENTERS = 16;
	localparam int DEF_MAX_DIM     = 16;

	localparam int MODE_W     = 2;
	localparam int IDX_W      = 4;
	localparam int VAL_W      = 16;
	localparam int KIND_W     = 2;
	localparam int DIST_W     = 36;
	localparam int MEAN_W     = 18;
	localparam int LR_W       = 16;
	localparam int THR_W      = 20;
	localparam int CNT_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 20;

	localparam logic [DIST_W-1:0] DIST_MAX = '1;
	localparam logic [MEAN_W-1:0] MEAN_MAX = '1;

	localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_EPOCH  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

	localparam logic [KIND_W-1:0] KIND_WINNER = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EPOCH  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CENTERS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LEN = 2'd3;

	localparam logic [LR_W-1:0]  RST_STEP_GAIN  = 16'd6554;
	localparam logic [THR_W-1:0] RST_THRESHOLD  = 20'd4;
	localparam logic [CNT_W-1:0] RST_CENTERS    = 5'd16;
	localparam logic [CNT_W-1:0] RST_VECTOR_LEN = 5'd16;

	typedef struct packed {
		logic              load;
		logic              host_rd;
		logic              smp_wr;
		logic              clr;
		logic              issue;
		logic              row_win;
		logic              full;
		logic              next_row;
		logic              cmp;
		logic              root_start;
		logic              root_step;
		logic              total_add;
		logic              div_start;
		logic              div_step;
		logic              emit;
		logic [KIND_W-1:0] kind;
	} okmu_cmd_t;

	typedef struct packed {
		logic smp_last;
		logic e_end;
		logic c_end;
		logic root_last;
		logic div_last;
	} okmu_sts_t;

endpackage
`default_nettype wire

// ===== sv/okmu_ctrl.sv =====
// Controller state machine: sequences distance scans, winner update and epoch reduction
`default_nettype none
module okmu_ctrl
	import okmu_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MODE_W-1:0] mode,
	input  wire okmu_sts_t         sts,
	output okmu_cmd_t              cmd,
	output logic                   busy
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_OUT,
		ST_DIST, ST_DIST_FL, ST_DIST_CMP,
		ST_UPD, ST_UPD_FL,
		ST_EP_SCAN, ST_EP_FL, ST_EP_SQ0, ST_EP_ROOT, ST_EP_NEXT,
		ST_EP_DV0, ST_EP_DIV, ST_EP_OUT
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (mode)
						MODE_LOAD: cmd.load = 1'b1;
						MODE_READ: begin
							cmd.host_rd = 1'b1;
							state_d     = ST_RD_OUT;
						end
						MODE_SAMPLE: begin
							cmd.smp_wr = 1'b1;
							if (sts.smp_last) begin
								cmd.clr = 1'b1;
								state_d = ST_DIST;
							end
						end
						MODE_EPOCH: begin
							cmd.clr = 1'b1;
							state_d = ST_EP_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_RD_OUT: begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_READ;
				state_d  = ST_IDLE;
			end
			ST_DIST: begin
				cmd.issue = 1'b1;
				if (sts.e_end)
					state_d = ST_DIST_FL;
			end
			ST_DIST_FL: state_d = ST_DIST_CMP;
			ST_DIST_CMP: begin
				cmd.cmp = 1'b1;
				if (sts.c_end) begin
					state_d = ST_UPD;
				end else begin
					cmd.next_row = 1'b1;
					state_d      = ST_DIST;
				end
			end
			ST_UPD: begin
				cmd.issue   = 1'b1;
				cmd.row_win = 1'b1;
				if (sts.e_end)
					state_d = ST_UPD_FL;
			end
			ST_UPD_FL: begin
				cmd.row_win = 1'b1;
				cmd.emit    = 1'b1;
				cmd.kind    = KIND_WINNER;
				state_d     = ST_IDLE;
			end
			ST_EP_SCAN: begin
				cmd.full  = 1'b1;
				cmd.issue = 1'b1;
				if (sts.e_end)
					state_d = ST_EP_FL;
			end
			ST_EP_FL: begin
				cmd.full = 1'b1;
				state_d  = ST_EP_SQ0;
			end
			ST_EP_SQ0: begin
				cmd.full       = 1'b1;
				cmd.root_start = 1'b1;
				state_d        = ST_EP_ROOT;
			end
			ST_EP_ROOT: begin
				cmd.full      = 1'b1;
				cmd.root_step = 1'b1;
				if (sts.root_last)
					state_d = ST_EP_NEXT;
			end
			ST_EP_NEXT: begin
				cmd.full      = 1'b1;
				cmd.total_add = 1'b1;
				if (sts.c_end) begin
					state_d = ST_EP_DV0;
				end else begin
					cmd.next_row = 1'b1;
					state_d      = ST_EP_SCAN;
				end
			end
			ST_EP_DV0: begin
				cmd.div_start = 1'b1;
				state_d       = ST_EP_DIV;
			end
			ST_EP_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = ST_EP_OUT;
			end
			ST_EP_OUT: begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_EPOCH;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule
`default_nettype wire

// ===== sv/okmu_datapath.sv =====
// Datapath: center/snapshot/sample memories, distance accumulator, update, root and divider
`default_nettype none
module okmu_datapath
	import okmu_pkg::*;
#(
	parameter int MAX_CENTERS = DEF_MAX_CENTERS,
	parameter int MAX_DIM     = DEF_MAX_DIM
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire okmu_cmd_t               cmd,
	output okmu_sts_t                    sts,
	input  wire logic [IDX_W-1:0]        center_index,
	input  wire logic [IDX_W-1:0]        element_index,
	input  wire logic signed [VAL_W-1:0] value,
	input  wire logic [LR_W-1:0]         step_gain,
	input  wire logic [THR_W-1:0]        change_threshold,
	input  wire logic [CNT_W-1:0]        centers_in_use,
	input  wire logic [CNT_W-1:0]        vector_length,
	output logic                         done,
	output logic [KIND_W-1:0]            result_kind,
	output logic [IDX_W-1:0]             winner_index,
	output logic [DIST_W-1:0]            distance_squared,
	output logic [MEAN_W-1:0]            mean_change,
	output logic                         converged,
	output logic signed [VAL_W-1:0]      read_value
);

	localparam int CW    = $clog2(MAX_CENTERS);
	localparam int DW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int NCW   = $clog2(MAX_CENTERS + 1);
	localparam int LNW   = $clog2(MAX_DIM + 1);
	localparam int AW    = CW + DW;
	localparam int DEPTH = 1 << AW;
	localparam int SQW   = 2 * VAL_W;
	localparam int DACW  = SQW + LNW;
	localparam int RW    = (DACW + 1) / 2;
	localparam int SW    = 2 * RW;
	localparam int TW    = RW + NCW;
	localparam int KW    = $clog2(TW + 1);

	logic [VAL_W-1:0] cen_mem [DEPTH];
	logic [VAL_W-1:0] snp_mem [DEPTH];
	logic [VAL_W-1:0] smp_mem [MAX_DIM];

	logic [NCW-1:0]  nc_eff;
	logic [LNW-1:0]  len_eff;
	logic [CW-1:0]   nc_last, c_end_v, row;
	logic [DW-1:0]   len_last, e_end_v;
	logic [AW-1:0]   scan_addr, host_addr, rd_addr;
	logic            host_ok, ei_ok;

	logic [CW-1:0]   c_q, win_q;
	logic [DW-1:0]   e_q;
	logic [KW-1:0]   k_q;
	logic            v_s1, upd_s1, full_s1, mask_s1, rd_ok_s1;
	logic [AW-1:0]   addr_s1;
	logic signed [VAL_W-1:0] cen_s1, snp_s1, smp_s1;

	logic signed [VAL_W:0]     opnd, diff;
	logic [VAL_W-1:0]          mag;
	logic [SQW-1:0]            sq;
	logic signed [2*VAL_W+1:0] prod;
	logic [VAL_W-1:0]          new_val;

	logic [DACW-1:0] acc_q, best_q;
	logic [SW-1:0]   rad_q;
	logic [RW:0]     rem_q;
	logic [RW-1:0]   root_q;
	logic [RW+2:0]   rem_sh, trial;
	logic [TW-1:0]   total_q, quo_q;
	logic [NCW-1:0]  drem_q;
	logic [NCW:0]    dtry;
	logic [MEAN_W-1:0] mean_sat;
	logic [DIST_W-1:0] dist_sat;

	// register clamping
	always_comb begin
		if (int'(centers_in_use) > MAX_CENTERS)
			nc_eff = NCW'(MAX_CENTERS);
		else if (centers_in_use == '0)
			nc_eff = NCW'(1);
		else
			nc_eff = NCW'(centers_in_use);
		if (int'(vector_length) > MAX_DIM)
			len_eff = LNW'(MAX_DIM);
		else if (vector_length == '0)
			len_eff = LNW'(1);
		else
			len_eff = LNW'(vector_length);
	end

	assign nc_last   = CW'(nc_eff - 1'b1);
	assign len_last  = DW'(len_eff - 1'b1);
	assign e_end_v   = cmd.full ? DW'(MAX_DIM - 1) : len_last;
	assign c_end_v   = cmd.full ? CW'(MAX_CENTERS - 1) : nc_last;
	assign row       = cmd.row_win ? win_q : c_q;
	assign scan_addr = {row, e_q};
	assign host_addr = {CW'(center_index), DW'(element_index)};
	assign rd_addr   = cmd.host_rd ? host_addr : scan_addr;
	assign ei_ok     = int'(element_index) < MAX_DIM;
	assign host_ok   = ei_ok && (int'(center_index) < MAX_CENTERS);

	assign sts.smp_last  = ei_ok && (int'(element_index) == int'(len_last));
	assign sts.e_end     = (e_q == e_end_v);
	assign sts.c_end     = (c_q == c_end_v);
	assign sts.root_last = (k_q == KW'(RW - 1));
	assign sts.div_last  = (k_q == KW'(TW - 1));

	// stage 1 arithmetic on registered memory data
	assign opnd    = full_s1 ? {snp_s1[VAL_W-1], snp_s1} : {smp_s1[VAL_W-1], smp_s1};
	assign diff    = opnd - {cen_s1[VAL_W-1], cen_s1};
	assign mag     = diff[VAL_W] ? VAL_W'(-diff) : VAL_W'(diff);
	assign sq      = mag * mag;
	assign prod    = $signed({1'b0, step_gain}) * diff;
	// floor of prod/65536, only the low bits survive the 16-bit wrap
	assign new_val = cen_s1 + prod[2*VAL_W-1:VAL_W];

	always_ff @(posedge clk) begin
		cen_s1 <= cen_mem[rd_addr];
		if (cmd.load && host_ok)
			cen_mem[host_addr] <= value;
		else if (v_s1 && upd_s1)
			cen_mem[addr_s1] <= new_val;
	end

	always_ff @(posedge clk) begin
		snp_s1 <= snp_mem[scan_addr];
		if (cmd.load && host_ok)
			snp_mem[host_addr] <= value;
		else if (v_s1 && full_s1)
			snp_mem[addr_s1] <= cen_s1;
	end

	always_ff @(posedge clk) begin
		smp_s1 <= smp_mem[e_q];
		if (cmd.smp_wr && ei_ok)
			smp_mem[DW'(element_index)] <= value;
	end

	always_ff @(posedge clk) begin
		addr_s1 <= {row, e_q};
		mask_s1 <= !cmd.full || ((c_q <= nc_last) && (e_q <= len_last));
	end

	// square root: two radicand bits per step
	assign rem_sh = {rem_q, rad_q[SW-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	// restoring divide by the active center count
	assign dtry   = {drem_q, quo_q[TW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q      <= '0;
			e_q      <= '0;
			k_q      <= '0;
			win_q    <= '0;
			v_s1     <= 1'b0;
			upd_s1   <= 1'b0;
			full_s1  <= 1'b0;
			rd_ok_s1 <= 1'b0;
			acc_q    <= '0;
			best_q   <= '0;
			rad_q    <= '0;
			rem_q    <= '0;
			root_q   <= '0;
			total_q  <= '0;
			quo_q    <= '0;
			drem_q   <= '0;
		end else begin
			v_s1     <= cmd.issue;
			upd_s1   <= cmd.row_win;
			full_s1  <= cmd.full;
			rd_ok_s1 <= host_ok;

			if (cmd.clr) begin
				c_q <= '0;
				e_q <= '0;
			end else begin
				if (cmd.issue)
					e_q <= sts.e_end ? '0 : e_q + 1'b1;
				if (cmd.next_row)
					c_q <= c_q + 1'b1;
			end

			if (cmd.clr || cmd.cmp || cmd.root_start)
				acc_q <= '0;
			else if (v_s1 && !upd_s1 && mask_s1)
				acc_q <= acc_q + DACW'(sq);

			if (cmd.cmp && ((c_q == '0) || (acc_q < best_q))) begin
				best_q <= acc_q;
				win_q  <= c_q;
			end

			if (cmd.root_start || cmd.div_start)
				k_q <= '0;
			else if (cmd.root_step || cmd.div_step)
				k_q <= k_q + 1'b1;

			if (cmd.root_start) begin
				rad_q  <= SW'(acc_q);
				rem_q  <= '0;
				root_q <= '0;
			end else if (cmd.root_step) begin
				rad_q <= rad_q << 2;
				if (rem_sh >= trial) begin
					rem_q  <= (RW+1)'(rem_sh - trial);
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q  <= (RW+1)'(rem_sh);
					root_q <= {root_q[RW-2:0], 1'b0};
				end
			end

			if (cmd.clr)
				total_q <= '0;
			else if (cmd.total_add)
				total_q <= total_q + TW'(root_q);

			if (cmd.div_start) begin
				quo_q  <= total_q;
				drem_q <= '0;
			end else if (cmd.div_step) begin
				if (dtry >= {1'b0, nc_eff}) begin
					drem_q <= NCW'(dtry - {1'b0, nc_eff});
					quo_q  <= {quo_q[TW-2:0], 1'b1};
				end else begin
					drem_q <= NCW'(dtry);
					quo_q  <= {quo_q[TW-2:0], 1'b0};
				end
			end
		end
	end

	assign mean_sat = (quo_q > TW'(MEAN_MAX)) ? MEAN_MAX : MEAN_W'(quo_q);
	assign dist_sat = (best_q > DACW'(DIST_MAX)) ? DIST_MAX : DIST_W'(best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done             <= 1'b0;
			result_kind      <= '0;
			winner_index     <= '0;
			distance_squared <= '0;
			mean_change      <= '0;
			converged        <= 1'b0;
			read_value       <= '0;
		end else begin
			done <= cmd.emit;
			if (cmd.emit) begin
				result_kind      <= cmd.kind;
				winner_index     <= '0;
				distance_squared <= '0;
				mean_change      <= '0;
				converged        <= 1'b0;
				read_value       <= '0;
				case (cmd.kind)
					KIND_WINNER: begin
						winner_index     <= IDX_W'(win_q);
						distance_squared <= dist_sat;
					end
					KIND_EPOCH: begin
						mean_change <= mean_sat;
						converged   <= (THR_W'(mean_sat) <= change_threshold);
					end
					KIND_READ: read_value <= rd_ok_s1 ? cen_s1 : '0;
					default: ;
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/online_kmeans_update.sv =====
// Top level of the online k-means center update block
//
// Usage: a transaction is taken when start is high and busy is low; mode selects
// load center element (no result), sample element, end epoch or read center element.
// Configuration is written through cfg_we/cfg_index/cfg_data while the block is idle.
// Each result shows on the result ports for one cycle with done high; the receiver
// cannot stall, so it must take every result in that cycle.
// A load, or a sample element that is not the last, is taken without going busy.
// A read answers after passing through ST_RD_OUT and the registered result outputs.
// The last sample element runs a distance scan with one center memory read per
// center element, then one pass over the winner's row to update it.
// End of epoch sweeps every center row and takes a square root of one result bit
// per cycle for each row, then runs a divider of one quotient bit per cycle.
// Reset clears the control state and restores the register defaults; memory
// contents are undefined until loaded.
`default_nettype none
module online_kmeans_update
	import okmu_pkg::*;
#(
	parameter int MAX_CENTERS = DEF_MAX_CENTERS,
	parameter int MAX_DIM     = DEF_MAX_DIM
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	output logic                         busy,
	input  wire logic [MODE_W-1:0]       mode,
	input  wire logic [IDX_W-1:0]        center_index,
	input  wire logic [IDX_W-1:0]        element_index,
	input  wire logic signed [VAL_W-1:0] value,
	output logic                         done,
	output logic [KIND_W-1:0]            result_kind,
	output logic [IDX_W-1:0]             winner_index,
	output logic [DIST_W-1:0]            distance_squared,
	output logic [MEAN_W-1:0]            mean_change,
	output logic                         converged,
	output logic signed [VAL_W-1:0]      read_value,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

	okmu_cmd_t        cmd;
	okmu_sts_t        sts;
	logic [LR_W-1:0]  step_gain_q;
	logic [THR_W-1:0] threshold_q;
	logic [CNT_W-1:0] centers_q;
	logic [CNT_W-1:0] vector_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_gain_q  <= RST_STEP_GAIN;
			threshold_q  <= RST_THRESHOLD;
			centers_q    <= RST_CENTERS;
			vector_len_q <= RST_VECTOR_LEN;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STEP_GAIN:  step_gain_q  <= cfg_data[LR_W-1:0];
				REG_THRESHOLD:  threshold_q  <= cfg_data[THR_W-1:0];
				REG_CENTERS:    centers_q    <= cfg_data[CNT_W-1:0];
				REG_VECTOR_LEN: vector_len_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	okmu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	okmu_datapath #(
		.MAX_CENTERS (MAX_CENTERS),
		.MAX_DIM     (MAX_DIM)
	) u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.center_index     (center_index),
		.element_index    (element_index),
		.value            (value),
		.step_gain        (step_gain_q),
		.change_threshold (threshold_q),
		.centers_in_use   (centers_q),
		.vector_length    (vector_len_q),
		.done             (done),
		.result_kind      (result_kind),
		.winner_index     (winner_index),
		.distance_squared (distance_squared),
		.mean_change      (mean_change),
		.converged        (converged),
		.read_value       (read_value)
	);

`ifndef NO_ASSERTIONS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result presented while still busy");

	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == MODE_READ)) |=> ##1 (done && (result_kind == KIND_READ)))
		else $error("read transaction did not answer after two cycles");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the online k-means center update block
`default_nettype none
module testbench;
	import okmu_pkg::*;

	typedef struct {
		logic [KIND_W-1:0]       kind;
		logic [IDX_W-1:0]        win;
		logic [DIST_W-1:0]       dsq;
		logic [MEAN_W-1:0]       mean;
		logic                    conv;
		logic signed [VAL_W-1:0] rval;
	} outcome_t;

	typedef struct {
		logic [MODE_W-1:0]       mode;
		logic [IDX_W-1:0]        ci;
		logic [IDX_W-1:0]        ei;
		logic signed [VAL_W-1:0] val;
		bit                      typed;
		outcome_t                want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [MODE_W-1:0] mode = MODE_LOAD;
	logic [IDX_W-1:0] center_index = '0;
	logic [IDX_W-1:0] element_index = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic done;
	logic [KIND_W-1:0] result_kind;
	logic [IDX_W-1:0] winner_index;
	logic [DIST_W-1:0] distance_squared;
	logic [MEAN_W-1:0] mean_change;
	logic converged;
	logic signed [VAL_W-1:0] read_value;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_STEP_GAIN;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	online_kmeans_update u_dut (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state
	logic signed [VAL_W-1:0] centers[256];
	logic signed [VAL_W-1:0] snapshot[256];
	logic signed [VAL_W-1:0] sample_buf[16];
	logic [LR_W-1:0]  lr_q;
	logic [THR_W-1:0] thr_q;
	logic [CNT_W-1:0] nc_q;
	logic [CNT_W-1:0] len_q;

	outcome_t pending[$];
	int unsigned errors = 0;
	int unsigned quiet = 0;
	bit no_idle = 1'b0;
	stim_row_t rows[$];

	function automatic int clamp16(logic [CNT_W-1:0] x);
		if (x < 1) return 1;
		if (x > 16) return 16;
		return int'(x);
	endfunction

	function automatic longint unsigned root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned sq_diff(longint signed a, longint signed b);
		longint signed d;
		d = a - b;
		return longint'(d * d);
	endfunction

	// Returns 1 when the transaction yields a result
	function automatic bit advance_model(logic [MODE_W-1:0] m, logic [IDX_W-1:0] ci,
			logic [IDX_W-1:0] ei, logic signed [VAL_W-1:0] v, output outcome_t o);
		int nc, len, win;
		longint unsigned d, best, total, mean;
		longint signed w, p;
		nc = clamp16(nc_q);
		len = clamp16(len_q);
		o = '{default: '0};
		case (m)
			MODE_LOAD: begin
				centers[ci*16+ei] = v;
				snapshot[ci*16+ei] = v;
				return 1'b0;
			end
			MODE_READ: begin
				o.kind = KIND_READ;
				o.rval = centers[ci*16+ei];
				return 1'b1;
			end
			MODE_SAMPLE: begin
				sample_buf[ei] = v;
				if (ei != len - 1) return 1'b0;
				best = 0;
				win = 0;
				for (int c = 0; c < nc; c++) begin
					d = 0;
					for (int e = 0; e < len; e++)
						d += sq_diff(sample_buf[e], centers[c*16+e]);
					if (c == 0 || d < best) begin
						best = d;
						win = c;
					end
				end
				for (int e = 0; e < len; e++) begin
					w = centers[win*16+e];
					p = longint'(lr_q) * (longint'(sample_buf[e]) - w);
					centers[win*16+e] = VAL_W'(w + (p >>> 16));
				end
				o.kind = KIND_WINNER;
				o.win = IDX_W'(win);
				o.dsq = (best > 64'(DIST_MAX)) ? DIST_MAX : DIST_W'(best);
				return 1'b1;
			end
			default: begin
				total = 0;
				for (int c = 0; c < nc; c++) begin
					d = 0;
					for (int e = 0; e < len; e++)
						d += sq_diff(centers[c*16+e], snapshot[c*16+e]);
					total += root_floor(d);
				end
				mean = total / nc;
				if (mean > 64'(MEAN_MAX)) mean = 64'(MEAN_MAX);
				snapshot = centers;
				o.kind = KIND_EPOCH;
				o.mean = MEAN_W'(mean);
				o.conv = (mean <= 64'(thr_q));
				return 1'b1;
			end
		endcase
	endfunction

	// One transaction; start is left high so back-to-back items need no drop
	task automatic issue(logic [MODE_W-1:0] m, logic [IDX_W-1:0] ci, logic [IDX_W-1:0] ei,
			logic signed [VAL_W-1:0] v, bit typed = 1'b0, outcome_t want = '{default: '0});
		outcome_t o;
		bit has;
		while (!no_idle && $urandom_range(0, 99) < 10) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		center_index <= ci;
		element_index <= ei;
		value <= v;
		do @(posedge clk); while (busy);
		has = advance_model(m, ci, ei, v, o);
		if (has) pending.push_back(typed ? want : o);
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic configure(logic [LR_W-1:0] lr, logic [THR_W-1:0] thr,
			logic [CNT_W-1:0] nc, logic [CNT_W-1:0] len);
		logic [CFG_DATA_W-1:0] junk;
		settle();
		junk = CFG_DATA_W'($urandom);
		cfg_we <= 1'b1;
		cfg_index <= REG_STEP_GAIN;
		cfg_data <= {junk[19:16], lr};
		@(posedge clk);
		cfg_index <= REG_THRESHOLD;
		cfg_data <= thr;
		@(posedge clk);
		cfg_index <= REG_CENTERS;
		cfg_data <= {junk[19:5], nc};
		@(posedge clk);
		cfg_index <= REG_VECTOR_LEN;
		cfg_data <= {junk[19:5], len};
		@(posedge clk);
		cfg_we <= 1'b0;
		lr_q = lr;
		thr_q = thr;
		nc_q = nc;
		len_q = len;
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 1)) return VAL_W'($urandom);
		return VAL_W'($urandom_range(0, 4095) - 2048);
	endfunction

	function automatic stim_row_t mk(logic [MODE_W-1:0] m, logic [IDX_W-1:0] ci,
			logic [IDX_W-1:0] ei, logic signed [VAL_W-1:0] v, bit typed = 1'b0,
			logic [KIND_W-1:0] k = KIND_WINNER, logic [IDX_W-1:0] win = '0,
			logic [DIST_W-1:0] dsq = '0, logic [MEAN_W-1:0] mean = '0,
			logic conv = 1'b0, logic signed [VAL_W-1:0] rv = '0);
		stim_row_t r;
		r.mode = m;
		r.ci = ci;
		r.ei = ei;
		r.val = v;
		r.typed = typed;
		r.want = '{kind: k, win: win, dsq: dsq, mean: mean, conv: conv, rval: rv};
		return r;
	endfunction

	task automatic random_phase(int n_items);
		int done_items, len, r;
		done_items = 0;
		len = clamp16(len_q);
		while (done_items < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				for (int e = 0; e < len; e++)
					issue(MODE_SAMPLE, IDX_W'($urandom), IDX_W'(e), pick_value());
				done_items += len;
			end else begin
				if (r < 70)
					issue(MODE_LOAD, IDX_W'($urandom), IDX_W'($urandom), pick_value());
				else if (r < 82)
					issue(MODE_READ, IDX_W'($urandom), IDX_W'($urandom), '0);
				else if (r < 90)
					issue(MODE_EPOCH, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
				else
					issue(MODE_SAMPLE, IDX_W'($urandom), IDX_W'($urandom), pick_value());
				done_items++;
			end
		end
	endtask

	// Result checker: the receiver never stalls
	always @(posedge clk) begin
		outcome_t x;
		if (done) begin
			if (pending.size() == 0) begin
				$error("unexpected result, kind %0d", result_kind);
				errors++;
			end else begin
				x = pending.pop_front();
				if (result_kind !== x.kind) begin
					$error("result_kind exp %0d got %0d", x.kind, result_kind);
					errors++;
				end
				if (winner_index !== x.win) begin
					$error("winner_index exp %0d got %0d", x.win, winner_index);
					errors++;
				end
				if (distance_squared !== x.dsq) begin
					$error("distance_squared exp %0d got %0d", x.dsq, distance_squared);
					errors++;
				end
				if (mean_change !== x.mean) begin
					$error("mean_change exp %0d got %0d", x.mean, mean_change);
					errors++;
				end
				if (converged !== x.conv) begin
					$error("converged exp %0d got %0d", x.conv, converged);
					errors++;
				end
				if (read_value !== x.rval) begin
					$error("read_value exp %0d got %0d", x.rval, read_value);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction or result
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet > 40000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		lr_q = RST_STEP_GAIN;
		thr_q = RST_THRESHOLD;
		nc_q = RST_CENTERS;
		len_q = RST_VECTOR_LEN;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// fill every center element and the whole sample buffer before any use
		for (int i = 0; i < 256; i++)
			issue(MODE_LOAD, IDX_W'(i / 16), IDX_W'(i % 16), pick_value());
		for (int e = 0; e < 16; e++)
			issue(MODE_SAMPLE, '0, IDX_W'(e), pick_value());

		configure(RST_STEP_GAIN, RST_THRESHOLD, 5'd2, 5'd1);
		rows.push_back(mk(MODE_LOAD, 4'd0, 4'd0, 16'sh7fff));
		rows.push_back(mk(MODE_LOAD, 4'd1, 4'd0, -16'sh8000));
		rows.push_back(mk(MODE_READ, 4'd0, 4'd0, '0, 1, KIND_READ, , , , , 16'sh7fff));
		rows.push_back(mk(MODE_READ, 4'd1, 4'd0, '0, 1, KIND_READ, , , , , -16'sh8000));
		rows.push_back(mk(MODE_EPOCH, 4'd0, 4'd0, '0, 1, KIND_EPOCH, , , 18'd0, 1'b1));
		rows.push_back(mk(MODE_SAMPLE, 4'd9, 4'd0, 16'sh7fff, 1, KIND_WINNER, 4'd0, 36'd0));
		rows.push_back(mk(MODE_SAMPLE, 4'd9, 4'd0, -16'sh8000, 1, KIND_WINNER, 4'd1, 36'd0));
		rows.push_back(mk(MODE_SAMPLE, 4'd0, 4'd0, 16'sh0000));
		rows.push_back(mk(MODE_EPOCH, 4'd15, 4'd15, 16'shffff));
		// equal centers: the lower index must win
		rows.push_back(mk(MODE_LOAD, 4'd0, 4'd0, 16'sd100));
		rows.push_back(mk(MODE_LOAD, 4'd1, 4'd0, 16'sd100));
		rows.push_back(mk(MODE_SAMPLE, 4'd0, 4'd0, 16'sd300, 1, KIND_WINNER, 4'd0, 36'd40000));
		rows.push_back(mk(MODE_READ, 4'd0, 4'd0, '0));
		// widest single-element distance
		rows.push_back(mk(MODE_LOAD, 4'd0, 4'd0, -16'sh8000));
		rows.push_back(mk(MODE_LOAD, 4'd1, 4'd0, -16'sh8000));
		rows.push_back(mk(MODE_SAMPLE, 4'd0, 4'd0, 16'sh7fff, 1, KIND_WINNER, 4'd0,
			36'd4294836225));
		rows.push_back(mk(MODE_READ, 4'd0, 4'd0, '0));
		rows.push_back(mk(MODE_SAMPLE, 4'd0, 4'd15, 16'sh1234));
		rows.push_back(mk(MODE_EPOCH, 4'd0, 4'd0, '0));
		rows.push_back(mk(MODE_READ, 4'd15, 4'd15, '0));
		foreach (rows[i])
			issue(rows[i].mode, rows[i].ci, rows[i].ei, rows[i].val, rows[i].typed,
				rows[i].want);

		configure(RST_STEP_GAIN, RST_THRESHOLD, RST_CENTERS, RST_VECTOR_LEN);
		random_phase(80);
		configure('0, '0, 5'd1, 5'd1);
		random_phase(50);
		no_idle = 1'b1;
		configure('1, '1, 5'd16, 5'd16);
		random_phase(80);
		no_idle = 1'b0;
		configure(LR_W'($urandom), THR_W'($urandom), 5'd0, 5'd0);
		random_phase(50);
		configure(LR_W'($urandom), THR_W'($urandom_range(0, 4000)),
			CNT_W'($urandom_range(17, 31)), CNT_W'($urandom_range(17, 31)));
		random_phase(70);
		configure(LR_W'($urandom), THR_W'($urandom_range(0, 200)),
			CNT_W'($urandom_range(2, 8)), CNT_W'($urandom_range(2, 6)));
		random_phase(80);

		settle();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
